// ----- rtl/pvc_pkg.sv -----
// shared types and constants of the two-wheel pi velocity controller
`timescale 1ns / 1ps
`default_nettype none
package pvc_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned MEAS_W     = 19;
  localparam int unsigned ERR_W      = 21;

  localparam logic [1:0] REG_PROP_GAIN    = 2'd0;
  localparam logic [1:0] REG_INT_GAIN     = 2'd1;
  localparam logic [1:0] REG_COUNT_SCALE  = 2'd2;
  localparam logic [1:0] REG_PERIOD_SCALE = 2'd3;

  localparam logic [15:0] PROP_GAIN_RST    = 16'd256;
  localparam logic [15:0] INT_GAIN_RST     = 16'd0;
  localparam logic [15:0] COUNT_SCALE_RST  = 16'd20017;
  localparam logic [15:0] PERIOD_SCALE_RST = 16'd3277;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAS,
    ST_ERR,
    ST_PROD,
    ST_INTEG,
    ST_IPROD,
    ST_SUM,
    ST_DONE
  } step_e;

  typedef struct packed {
    logic  load;
    step_e step;
  } pvc_ctrl_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] int_gain;
    logic [15:0] count_scale;
    logic [15:0] period_scale;
  } pvc_cfg_t;

endpackage
`default_nettype wire

// ----- rtl/pvc_if.sv -----
// valid/ready channel interfaces for input and result items
`timescale 1ns / 1ps
`default_nettype none
interface pvc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] count_left;
  logic signed [15:0] count_right;
  logic signed [15:0] target_left;
  logic signed [15:0] target_right;

  modport source (output valid, count_left, count_right, target_left, target_right,
                  input ready);
  modport sink (input valid, count_left, count_right, target_left, target_right,
                output ready);
endinterface

interface pvc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] effort_left;
  logic signed [15:0] effort_right;

  modport source (output valid, effort_left, effort_right, input ready);
  modport sink (input valid, effort_left, effort_right, output ready);
endinterface
`default_nettype wire

// ----- rtl/pvc_cfg.sv -----
// apb register file for gains and scales
`timescale 1ns / 1ps
`default_nettype none
module pvc_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pvc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output pvc_pkg::pvc_cfg_t                    cfg_o
);

  pvc_pkg::pvc_cfg_t cfg_q, cfg_d;
  logic [1:0]        reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        pvc_pkg::REG_PROP_GAIN:    cfg_d.prop_gain    = pwdata[15:0];
        pvc_pkg::REG_INT_GAIN:     cfg_d.int_gain     = pwdata[15:0];
        pvc_pkg::REG_COUNT_SCALE:  cfg_d.count_scale  = pwdata[15:0];
        pvc_pkg::REG_PERIOD_SCALE: cfg_d.period_scale = pwdata[15:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pvc_pkg::REG_PROP_GAIN:    prdata = {16'd0, cfg_q.prop_gain};
      pvc_pkg::REG_INT_GAIN:     prdata = {16'd0, cfg_q.int_gain};
      pvc_pkg::REG_COUNT_SCALE:  prdata = {16'd0, cfg_q.count_scale};
      pvc_pkg::REG_PERIOD_SCALE: prdata = {16'd0, cfg_q.period_scale};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain    <= pvc_pkg::PROP_GAIN_RST;
      cfg_q.int_gain     <= pvc_pkg::INT_GAIN_RST;
      cfg_q.count_scale  <= pvc_pkg::COUNT_SCALE_RST;
      cfg_q.period_scale <= pvc_pkg::PERIOD_SCALE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pvc_seq.sv -----
// step sequencer shared by both wheel lanes
`timescale 1ns / 1ps
`default_nettype none
module pvc_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          out_free_i,
  output pvc_pkg::pvc_ctrl_t ctrl_o
);

  pvc_pkg::step_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pvc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_ready_o  = (state_q == pvc_pkg::ST_IDLE);
    ctrl_o.load = in_valid_i && in_ready_o;
    ctrl_o.step = state_q;
    state_d     = state_q;
    case (state_q)
      pvc_pkg::ST_IDLE:  begin
        if (in_valid_i) state_d = pvc_pkg::ST_MEAS;
      end
      pvc_pkg::ST_MEAS:  state_d = pvc_pkg::ST_ERR;
      pvc_pkg::ST_ERR:   state_d = pvc_pkg::ST_PROD;
      pvc_pkg::ST_PROD:  state_d = pvc_pkg::ST_INTEG;
      pvc_pkg::ST_INTEG: state_d = pvc_pkg::ST_IPROD;
      pvc_pkg::ST_IPROD: state_d = pvc_pkg::ST_SUM;
      pvc_pkg::ST_SUM:   state_d = pvc_pkg::ST_DONE;
      pvc_pkg::ST_DONE:  begin
        // hold until the result register can take the item
        if (out_free_i) state_d = pvc_pkg::ST_IDLE;
      end
      default:           state_d = pvc_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/pvc_lane.sv -----
// one wheel lane: measure, error, saturating integrator and pi effort
`timescale 1ns / 1ps
`default_nettype none
module pvc_lane (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pvc_pkg::pvc_ctrl_t  ctrl_i,
  input  wire pvc_pkg::pvc_cfg_t   cfg_i,
  input  wire logic signed [15:0]  count_i,
  input  wire logic signed [15:0]  target_i,
  output logic signed [15:0]       effort_o
);

  logic signed [15:0]              cnt_q, tgt_q;
  logic [16:0]                     cnt_mag, tgt_mag;
  logic [32:0]                     meas_p_q;
  logic [33:0]                     meas_rnd;
  logic [pvc_pkg::MEAS_W-1:0]      meas;
  logic signed [pvc_pkg::ERR_W-1:0] err_q, err_d;
  logic signed [37:0]              err_ext, ps_ext, kp_ext;
  logic signed [37:0]              inc_p_q, inc_adj, pk_q;
  logic signed [25:0]              inc;
  logic signed [32:0]              acc;
  logic signed [31:0]              integ_q, integ_d;
  logic signed [48:0]              integ_ext, ki_ext, pi_q;
  logic signed [49:0]              sum_raw, sum_d, sum_q, eff_adj;
  logic signed [33:0]              eff_full;

  assign cnt_mag = cnt_q[15] ? (17'd0 - {1'b1, cnt_q}) : {1'b0, cnt_q};
  assign tgt_mag = tgt_q[15] ? (17'd0 - {1'b1, tgt_q}) : {1'b0, tgt_q};

  // measured speed rounded half up, q.4
  assign meas_rnd = {1'b0, meas_p_q} + 34'd2048;
  assign meas     = meas_rnd[pvc_pkg::MEAS_W+11:12];
  assign err_d    = $signed({4'd0, tgt_mag}) - $signed({2'd0, meas});

  assign err_ext = 38'(err_q);
  assign ps_ext  = 38'({1'b0, cfg_i.period_scale});
  assign kp_ext  = 38'({1'b0, cfg_i.prop_gain});

  // divide by 4096 toward zero
  assign inc_adj = inc_p_q[37] ? (inc_p_q + 38'sd4095) : inc_p_q;
  assign inc     = inc_adj[37:12];
  assign acc     = 33'(integ_q) + 33'(inc);

  always_comb begin
    if (acc[32] != acc[31]) begin
      integ_d = acc[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      integ_d = acc[31:0];
    end
  end

  assign integ_ext = 49'(integ_q);
  assign ki_ext    = 49'({1'b0, cfg_i.int_gain});

  assign sum_raw = (50'(pk_q) <<< 4) + 50'(pi_q);

  always_comb begin
    if (tgt_q == 16'sd0) begin
      sum_d = 50'sd0;
    end else if (tgt_q[15]) begin
      sum_d = -sum_raw;
    end else begin
      sum_d = sum_raw;
    end
  end

  // divide by 65536 toward zero, then clamp to 16 bits
  assign eff_adj  = sum_q[49] ? (sum_q + 50'sd65535) : sum_q;
  assign eff_full = eff_adj[49:16];

  always_comb begin
    if (eff_full > 34'sd32767) begin
      effort_o = 16'sh7fff;
    end else if (eff_full < -34'sd32768) begin
      effort_o = 16'sh8000;
    end else begin
      effort_o = eff_full[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= 32'sd0;
    end else if (ctrl_i.step == pvc_pkg::ST_INTEG) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cnt_q <= count_i;
      tgt_q <= target_i;
    end
    case (ctrl_i.step)
      pvc_pkg::ST_MEAS:  meas_p_q <= 33'(cnt_mag) * 33'(cfg_i.count_scale);
      pvc_pkg::ST_ERR:   err_q    <= err_d;
      pvc_pkg::ST_PROD:  inc_p_q  <= err_ext * ps_ext;
      pvc_pkg::ST_INTEG: pk_q     <= err_ext * kp_ext;
      pvc_pkg::ST_IPROD: pi_q     <= integ_ext * ki_ext;
      pvc_pkg::ST_SUM:   sum_q    <= sum_d;
      default:           ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/pvc_merge.sv -----
// merging stage: joins both lane efforts into one result item register
`timescale 1ns / 1ps
`default_nettype none
module pvc_merge (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pvc_pkg::pvc_ctrl_t  ctrl_i,
  input  wire logic signed [15:0]  effort_left_i,
  input  wire logic signed [15:0]  effort_right_i,
  output logic                     out_free_o,
  pvc_out_if.source                out_o
);

  logic               valid_q, valid_d;
  logic               load;
  logic signed [15:0] left_q, right_q;

  assign out_free_o = !valid_q || out_o.ready;
  assign load       = (ctrl_i.step == pvc_pkg::ST_DONE) && out_free_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      left_q  <= effort_left_i;
      right_q <= effort_right_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.effort_left  = left_q;
  assign out_o.effort_right = right_q;

endmodule
`default_nettype wire

// ----- rtl/two_wheel_pi_velocity_control_core.sv -----
// flow: an accepted item passes the steps meas, err, prod, integ, iprod, sum and done,
// where it loads the output register once that register is free; the seven-step shared
// sequencer driving both wheel lanes takes the next item only when back in idle
// each lane runs four dependent multiplies, one per step; steps and stalls set the rate
// reset: gains and scales return to defaults, both integrators clear to zero,
// no result pending
`timescale 1ns / 1ps
`default_nettype none
module two_wheel_pi_velocity_control_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pvc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  pvc_in_if.sink                               in_i,
  pvc_out_if.source                            out_o
);

  pvc_pkg::pvc_cfg_t  cfg;
  pvc_pkg::pvc_ctrl_t ctrl;
  logic               out_free;
  logic signed [15:0] effort_left, effort_right;

  pvc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pvc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  pvc_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg),
    .count_i  (in_i.count_left),
    .target_i (in_i.target_left),
    .effort_o (effort_left)
  );

  pvc_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg),
    .count_i  (in_i.count_right),
    .target_i (in_i.target_right),
    .effort_o (effort_right)
  );

  pvc_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .effort_left_i  (effort_left),
    .effort_right_i (effort_right),
    .out_free_o     (out_free),
    .out_o          (out_o)
  );

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// testbench for the two-wheel pi velocity controller: directed and random items checked in order
`timescale 1ns / 1ps
module tb_top;
  import pvc_pkg::*;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } effort_pair_t;

  typedef enum {MIX_ITEMS, SPIN_ITEMS} stim_e;

  // predicts both wheel efforts and keeps the ones still owed by the block
  class effort_board;
    longint kp, ki, cnt_scale, per_scale;
    logic signed [31:0] integ_l, integ_r;
    effort_pair_t expected_efforts[$];
    int mismatches;

    function new();
      kp = longint'(PROP_GAIN_RST);
      ki = longint'(INT_GAIN_RST);
      cnt_scale = longint'(COUNT_SCALE_RST);
      per_scale = longint'(PERIOD_SCALE_RST);
      integ_l = '0;
      integ_r = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_PROP_GAIN:    kp = longint'(val);
        REG_INT_GAIN:     ki = longint'(val);
        REG_COUNT_SCALE:  cnt_scale = longint'(val);
        REG_PERIOD_SCALE: per_scale = longint'(val);
        default: ;
      endcase
    endfunction

    function void flag(string what, longint expv, longint actv);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", what, expv, actv);
    endfunction

    function logic signed [15:0] wheel_effort(logic signed [15:0] count,
                                              logic signed [15:0] target,
                                              inout logic signed [31:0] integ);
      longint c, t, meas, err, acc, sum, eff;
      c = longint'(count);
      t = longint'(target);
      if (c < 0) c = -c;
      meas = (c * cnt_scale + 2048) / 4096;
      err = ((t < 0) ? -t : t) - meas;
      acc = longint'(integ) + (err * per_scale) / 4096;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      integ = 32'(acc);
      sum = kp * err * 16 + ki * acc;
      if (t < 0) sum = -sum;
      else if (t == 0) sum = 0;
      eff = sum / 65536;
      if (eff > 32767) eff = 32767;
      if (eff < -32768) eff = -32768;
      return 16'(eff);
    endfunction

    function void note_input(logic signed [15:0] cl, logic signed [15:0] cr,
                             logic signed [15:0] tl, logic signed [15:0] tr);
      effort_pair_t e;
      e.left = wheel_effort(cl, tl, integ_l);
      e.right = wheel_effort(cr, tr, integ_r);
      expected_efforts.push_back(e);
    endfunction

    function void check_result(logic signed [15:0] el, logic signed [15:0] er);
      effort_pair_t e;
      if (expected_efforts.size() == 0) begin
        flag("unexpected result, effort_left", 0, el);
        return;
      end
      e = expected_efforts.pop_front();
      if (el !== e.left) flag("effort_left", e.left, el);
      if (er !== e.right) flag("effort_right", e.right, er);
    endfunction

    function int pending();
      return expected_efforts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic no_gaps;
  logic hold_off_req;

  effort_board board = new();

  pvc_in_if in_bus ();
  pvc_out_if out_bus ();

  two_wheel_pi_velocity_control_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_bus),
    .out_o   (out_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      board.note_input(in_bus.count_left, in_bus.count_right,
                       in_bus.target_left, in_bus.target_right);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      board.check_result(out_bus.effort_left, out_bus.effort_right);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int k;
    if (no_gaps) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_word();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 16'($urandom());
    if (k < 80) return 16'(int'($urandom_range(0, 4000)) - 2000);
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  task automatic send_item(input logic signed [15:0] cl, input logic signed [15:0] cr,
                           input logic signed [15:0] tl, input logic signed [15:0] tr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.count_left <= cl;
    in_bus.count_right <= cr;
    in_bus.target_left <= tl;
    in_bus.target_right <= tr;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    // upper bits are junk, the block keeps only the low half
    pwdata <= {16'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, val);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'd0, val}) board.flag("prdata", longint'(val), longint'(prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] pg, input logic [15:0] ig,
                                input logic [15:0] cs, input logic [15:0] ps);
    in_bus.valid <= 1'b0;
    // let the input monitor note the last accepted item first
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    write_reg(REG_PROP_GAIN, pg);
    write_reg(REG_INT_GAIN, ig);
    write_reg(REG_COUNT_SCALE, cs);
    write_reg(REG_PERIOD_SCALE, ps);
  endtask

  // spin items: fast wheels with slow targets drive the integrators to the low limit
  task automatic run_phase(input int n, input stim_e kind);
    logic signed [15:0] f [4];
    int v;
    repeat (n) begin
      for (int j = 0; j < 4; j++) begin
        if (kind == MIX_ITEMS) begin
          f[j] = pick_word();
        end else if (j < 2) begin
          v = $urandom_range(28000, 32768);
          f[j] = 16'($urandom_range(0, 1) ? -v : v);
        end else begin
          f[j] = 16'(int'($urandom_range(0, 4000)) - 2000);
        end
      end
      send_item(f[0], f[1], f[2], f[3]);
    end
  endtask

  initial begin : result_sink
    int gap;
    out_bus.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = 400;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin : main_seq
    int n;
    in_bus.valid = 1'b0;
    in_bus.count_left = '0;
    in_bus.count_right = '0;
    in_bus.target_left = '0;
    in_bus.target_right = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    no_gaps = 1'b0;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults
    send_item(0, 0, 0, 0);
    send_item(32767, -32768, 32767, -32768);
    send_item(-32768, 32767, -32768, 32767);
    send_item(1000, -1000, 0, 0);
    send_item(-1, 1, -1, 1);
    send_item(0, 0, 32767, -32768);
    send_item(32767, 32767, 1, -1);
    send_item(-32768, -32768, 0, 0);
    send_item(100, -100, 1600, -1600);
    send_item(-5000, 5000, -200, 200);
    send_item(16'sh5555, -16'sh5556, 16'sh5555, -16'sh5556);
    send_item(-16'sh5556, 16'sh5555, -16'sh5556, 16'sh5555);

    // everything at full scale: effort saturates both ways
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(0, 0, 32767, -32768);
    send_item(0, 0, -32768, 32767);
    send_item(32767, -32768, 0, 0);
    send_item(32767, -32768, 1, -1);
    send_item(-32768, 32767, -1, 1);
    send_item(1, -1, 32767, -32767);
    send_item(0, 0, 0, 0);
    send_item(12345, -12345, -4321, 4321);

    apply_settings(PROP_GAIN_RST, INT_GAIN_RST, COUNT_SCALE_RST, PERIOD_SCALE_RST);
    run_phase(200, MIX_ITEMS);

    apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    no_gaps = 1'b1;
    run_phase(100, MIX_ITEMS);
    no_gaps = 1'b0;

    apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
                   16'hFFFF, 16'hFFFF);
    run_phase(350, SPIN_ITEMS);

    apply_settings(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
    hold_off_req = 1'b1;
    run_phase(250, MIX_ITEMS);

    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(150, MIX_ITEMS);

    apply_settings(16'($urandom_range(0, 512)), 16'($urandom_range(0, 64)),
                   16'($urandom()), 16'($urandom()));
    run_phase(250, MIX_ITEMS);

    apply_settings(PROP_GAIN_RST, INT_GAIN_RST, COUNT_SCALE_RST, PERIOD_SCALE_RST);
    run_phase(300, MIX_ITEMS);

    in_bus.valid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < 5000 && board.pending() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
